// File: rtl/core/sbad_pkg.sv
// Shared types and constants for the system bus address decoder.
// No dependencies; imported by sbad_decode and system_bus_address_decoder.
package sbad_pkg;

  // Decoded bus target.
  typedef enum logic [3:0] {
    TGT_RAM       = 4'd0,
    TGT_ROM       = 4'd1,
    TGT_VIA1      = 4'd2,
    TGT_VIA2      = 4'd3,
    TGT_SCC       = 4'd4,
    TGT_SCSI_BERR = 4'd5,
    TGT_SCSI_DMA  = 4'd6,
    TGT_SCSI_REG  = 4'd7,
    TGT_SCSI_PDMA = 4'd8,
    TGT_SOUND     = 4'd9,
    TGT_FLOPPY    = 4'd10,
    TGT_SLOT      = 4'd11,
    TGT_OPEN      = 4'd12
  } target_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TRANSLATE = 2'd0;
  localparam logic [1:0] CFG_OVERLAY   = 2'd1;
  localparam logic [1:0] CFG_RAM_BYTES = 2'd2;

  localparam logic [30:0] RAM_BYTES_RESET = 31'd8388608;

  // Live configuration seen by the decoder.
  typedef struct packed {
    logic        translate_enable;
    logic        boot_overlay;
    logic [30:0] ram_bytes;
  } cfg_t;

  // One decoded access.
  typedef struct packed {
    target_t     target;
    logic [31:0] local_offset;
    logic [3:0]  reg_select;
    logic        serial_channel;
    logic        serial_data_port;
    logic [31:0] physical_address;
  } result_t;

endpackage

// File: rtl/core/system_bus_address_decoder.sv
// Top level of the system bus address decoder: register stages and config port.
// Depends on sbad_pkg and sbad_decode.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+----------------------------------
//  in_     | slave     | in_tvalid/in_tready   | tdata: bus_address; tuser: is_store
//  out_    | master    | out_tvalid/out_tready | tdata: decode fields; tuser: target
//  cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// Each request is held first in the input register and then in the result
// register, from which its result is presented; a new request can be accepted
// every cycle while the output is not stalled. The only logic between the
// stages is the decode in sbad_decode. Reset clears both stage valid flags and
// loads the configuration defaults (translation off, boot overlay on, 8 MiB RAM).
// A stall on the output holds the result register and backs up into the input
// register; each stage still takes a new request in the cycle its content leaves.
module system_bus_address_decoder #(
  parameter int ROM_BYTES = 262144
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] bus_address
  input  logic [0:0]  in_tuser,   // [0] is_store
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] local_offset, [35:32] reg_select, [36] serial_channel,
  // [37] serial_data_port, [69:38] physical_address, [71:70] zero
  output logic [71:0] out_tdata,
  output logic [3:0]  out_tuser,  // [3:0] target
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import sbad_pkg::*;

  cfg_t        cfg_r;
  logic        s1_valid_r;
  logic [31:0] s1_addr_r;
  logic        s1_store_r;
  logic        out_valid_r;
  result_t     out_res_r;
  result_t     dec_res;
  logic        out_free;
  logic        s1_free;

  // Always taken; the user must write configuration only while idle, unchecked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.translate_enable <= 1'b0;
      cfg_r.boot_overlay     <= 1'b1;
      cfg_r.ram_bytes        <= RAM_BYTES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRANSLATE: cfg_r.translate_enable <= cfg_data[0];
        CFG_OVERLAY:   cfg_r.boot_overlay     <= cfg_data[0];
        CFG_RAM_BYTES: cfg_r.ram_bytes        <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register can load when empty or when its content is taken.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_free   = !s1_valid_r || out_free;
  assign in_tready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_tvalid) begin
      s1_addr_r  <= in_tdata;
      s1_store_r <= in_tuser[0];
    end
  end

  sbad_decode #(
    .ROM_BYTES(ROM_BYTES)
  ) u_decode (
    .cfg_i     (cfg_r),
    .addr_i    (s1_addr_r),
    .is_store_i(s1_store_r),
    .res_o     (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.target;
  assign out_tdata  = {2'b00,
                       out_res_r.physical_address,
                       out_res_r.serial_data_port,
                       out_res_r.serial_channel,
                       out_res_r.reg_select,
                       out_res_r.local_offset};

endmodule

// File: rtl/core/sbad_decode.sv
// Combinational address translation and target decode for one access.
// Depends on sbad_pkg for the configuration and result types.
module sbad_decode #(
  parameter int ROM_BYTES = 262144
) (
  input  sbad_pkg::cfg_t    cfg_i,
  input  logic [31:0]       addr_i,
  input  logic              is_store_i,
  output sbad_pkg::result_t res_o
);
  import sbad_pkg::*;

  localparam logic [31:0] RomSize = 32'(ROM_BYTES);
  localparam logic [31:0] RomMask = 32'(ROM_BYTES - 1);
  localparam logic [31:0] MirrorBase = 32'h0080_0000;
  localparam logic [31:0] MirrorEnd  = 32'h00C0_0000;

  logic [31:0] phys;
  logic [19:0] io_off;
  logic [31:0] win_off;
  logic [12:0] rel;
  logic        pdma;

  // 24-bit to 32-bit translation when enabled; otherwise the address passes through.
  always_comb begin
    phys = addr_i;
    if (cfg_i.translate_enable) begin
      priority if (addr_i[23:20] == 4'h8) begin
        phys = {8'h40, addr_i[23:0]};
      end else if (addr_i[23:20] == 4'hF) begin
        phys = {8'h50, addr_i[23:0]};
      end else if (addr_i[23:20] >= 4'h9) begin
        // The slot nibble lands in bits 27:24; bits 23:20 are cleared.
        phys = {4'hF, addr_i[23:20], 4'h0, addr_i[19:0]};
      end else begin
        phys = {8'h00, addr_i[23:0]};
      end
    end
  end

  assign io_off  = phys[19:0];
  assign win_off = {19'd0, io_off[12:0]};
  assign rel     = io_off[12:0];
  // Pseudo-DMA: writes hit one port, reads hit a four-byte group.
  assign pdma    = is_store_i ? (rel == 13'h200) : (rel[12:2] == 11'h098);

  always_comb begin
    res_o                  = '0;
    res_o.target           = TGT_OPEN;
    res_o.physical_address = phys;
    priority if (phys[31:30] == 2'b00) begin
      priority if (cfg_i.boot_overlay) begin
        if (!is_store_i && phys < RomSize) begin
          res_o.target       = TGT_ROM;
          res_o.local_offset = phys;
        end
      end else if (phys < {1'b0, cfg_i.ram_bytes}) begin
        res_o.target       = TGT_RAM;
        res_o.local_offset = phys;
      end else if ({1'b0, cfg_i.ram_bytes} == MirrorBase && phys < MirrorEnd) begin
        res_o.target       = TGT_RAM;
        res_o.local_offset = phys - MirrorBase;
      end else begin
        res_o.target       = TGT_OPEN;
      end
    end else if (phys[31:28] == 4'h4) begin
      if (!is_store_i) begin
        res_o.target       = TGT_ROM;
        res_o.local_offset = phys & RomMask;
      end
    end else if (phys[31:24] == 8'h50) begin
      priority if (io_off < 20'h02000
                   || (io_off >= 20'h40000 && io_off < 20'h42000)) begin
        res_o.target       = TGT_VIA1;
        res_o.local_offset = win_off;
        res_o.reg_select   = io_off[12:9];
      end else if (io_off < 20'h04000) begin
        res_o.target       = TGT_VIA2;
        res_o.local_offset = win_off;
        res_o.reg_select   = io_off[12:9];
      end else if (io_off < 20'h06000) begin
        res_o.target           = TGT_SCC;
        res_o.local_offset     = win_off;
        res_o.serial_channel   = io_off[1];
        res_o.serial_data_port = io_off[2];
      end else if (io_off < 20'h08000) begin
        res_o.target       = TGT_SCSI_BERR;
        res_o.local_offset = win_off;
      end else if (io_off >= 20'h12000 && io_off < 20'h14000) begin
        res_o.target       = TGT_SCSI_DMA;
        res_o.local_offset = win_off;
      end else if (io_off >= 20'h10000 && io_off < 20'h12000) begin
        res_o.target       = pdma ? TGT_SCSI_PDMA : TGT_SCSI_REG;
        res_o.local_offset = win_off;
        res_o.reg_select   = {1'b0, rel[6:4]};
      end else if (io_off >= 20'h14000 && io_off < 20'h16000) begin
        res_o.target       = TGT_SOUND;
        res_o.local_offset = win_off;
      end else if (io_off >= 20'h16000 && io_off < 20'h18000) begin
        res_o.target       = TGT_FLOPPY;
        res_o.local_offset = win_off;
        res_o.reg_select   = io_off[12:9];
      end else begin
        res_o.target       = TGT_OPEN;
      end
    end else if (phys[31:28] >= 4'h9 && phys[31:24] != 8'hFF) begin
      res_o.target       = TGT_SLOT;
      res_o.local_offset = phys;
    end else begin
      res_o.target       = TGT_OPEN;
    end
  end

endmodule
